>>> sv/swvc_pkg.sv
// ---------------------------------------------------------------------------
// swvc_pkg
// shared constants, register indexes and lane control word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swvc_pkg;

   localparam int WINDOW_MAX_DEF  = 256;
   localparam int CHANNELS_DEF    = 8;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int WIN_LEN_BITS    = 9;
   localparam int ACT_BITS        = 4;
   localparam int CSR_DATA_BITS   = 9;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CHAN_BITS       = 3;
   localparam int RESULT_BITS     = 48;
   localparam int RSP_FIELD_BITS  = CHAN_BITS + 3 * RESULT_BITS;
   localparam int RSP_DATA_BITS   = (RSP_FIELD_BITS + 7) / 8 * 8;
   localparam int FRAC_SHIFT      = 8;
   localparam int DIV_STEP        = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LEN      = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_CHANNELS = 1'd1;

   localparam logic [WIN_LEN_BITS-1:0] WINDOW_LEN_RESET = 9'd120;
   localparam logic [ACT_BITS-1:0]     ACTIVE_RESET     = 4'd8;

   // one strobe per pipeline step, same for every lane
   typedef struct packed {
      logic clear;
      logic read;
      logic write;
      logic product;
      logic accumulate;
      logic divide;
      logic multiply;
      logic finish;
   } swvc_ctl_type;

endpackage

>>> sv/swvc_ram.sv
// ---------------------------------------------------------------------------
// swvc_ram
// generic simple dual port ram, registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swvc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/swvc_div.sv
// ---------------------------------------------------------------------------
// swvc_div
// iterative signed mean: trunc(sum * 256 / n), four quotient bits a cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swvc_div #(
   parameter int SUM_W = 25,
   parameter int DIV_W = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] sum,
   input  logic [DIV_W-1:0]        divisor,
   output logic                    busy,
   output logic signed [SUM_W+8:0] mean
);

   import swvc_pkg::*;

   localparam int DW    = SUM_W + FRAC_SHIFT;
   localparam int ITER  = (DW + DIV_STEP - 1) / DIV_STEP;
   localparam int PW    = ITER * DIV_STEP;
   localparam int CNT_W = $clog2(ITER + 2);

   logic [PW-1:0]          q_ff, q_in;
   logic [DIV_W:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]       divisor_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff;
   logic                   neg_ff;
   logic signed [DW:0]     mean_ff;
   logic [SUM_W-1:0]       mag;

   assign mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

   // restoring steps, remainder stays below the divisor
   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      for (int k = 0; k < DIV_STEP; k++) begin
         rem_in = {rem_in[DIV_W-1:0], q_in[PW-1]};
         q_in   = {q_in[PW-2:0], 1'b0};
         if (rem_in >= {1'b0, divisor_ff}) begin
            rem_in  = rem_in - {1'b0, divisor_ff};
            q_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff    <= 1'b1;
         cnt_ff     <= CNT_W'(ITER + 1);
         q_ff       <= PW'({mag, {FRAC_SHIFT{1'b0}}});
         rem_ff     <= '0;
         divisor_ff <= divisor;
         neg_ff     <= sum[SUM_W-1];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            mean_ff <= neg_ff ? -$signed({1'b0, q_ff[DW-1:0]})
                              :  $signed({1'b0, q_ff[DW-1:0]});
         end else begin
            q_ff   <= q_in;
            rem_ff <= rem_in;
         end
      end
   end

   assign busy = busy_ff;
   assign mean = mean_ff;

endmodule

>>> sv/swvc_lane.sv
// ---------------------------------------------------------------------------
// swvc_lane
// one channel: ring store, running sums, means and second moments
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swvc_lane #(
   parameter int WINDOW_MAX  = swvc_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swvc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  swvc_pkg::swvc_ctl_type                      ctl,
   input  logic [$clog2(WINDOW_MAX)-1:0]               addr,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]             win_n,
   input  logic signed [SAMPLE_BITS-1:0]               x_new,
   input  logic signed [SAMPLE_BITS-1:0]               w_new,
   input  logic signed [SAMPLE_BITS-1:0]               w_old,
   input  logic signed [SAMPLE_BITS+$clog2(WINDOW_MAX)+9:0] w_mean,
   output logic signed [SAMPLE_BITS-1:0]               x_old,
   output logic signed [SAMPLE_BITS+$clog2(WINDOW_MAX)+9:0] x_mean,
   output logic signed [swvc_pkg::RESULT_BITS-1:0]     x_var,
   output logic signed [swvc_pkg::RESULT_BITS-1:0]     wx_cov,
   output logic                                        busy
);

   import swvc_pkg::*;

   localparam int AW  = $clog2(WINDOW_MAX);
   localparam int NW  = $clog2(WINDOW_MAX + 1);
   localparam int XSW = SAMPLE_BITS + AW + 1;
   localparam int SQW = 2 * SAMPLE_BITS + AW;
   localparam int WXW = SQW + 1;
   localparam int MW  = XSW + 9;
   localparam int PB  = 2 * SAMPLE_BITS;

   logic [SAMPLE_BITS-1:0]       rdata;
   logic signed [PB-1:0]         sq_new_ff, sq_old_ff, wx_new_ff, wx_old_ff;
   logic signed [SAMPLE_BITS:0]  dx_ff;
   logic signed [XSW-1:0]        x_total_ff;
   logic signed [SQW-1:0]        sq_total_ff;
   logic signed [WXW-1:0]        wx_total_ff;
   logic signed [SQW+8:0]        sq_mean;
   logic signed [WXW+8:0]        wx_mean;
   logic signed [2*MW-1:0]       xx_ff, wxm_ff;
   logic signed [RESULT_BITS-1:0] x_var_ff, wx_cov_ff;
   logic                          busy_x, busy_sq, busy_wx;

   swvc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock (clock),
      .we    (ctl.clear | ctl.write),
      .waddr (addr),
      .wdata (ctl.clear ? '0 : x_new),
      .re    (ctl.read),
      .raddr (addr),
      .rdata (rdata)
   );

   assign x_old = $signed(rdata);

   always_ff @(posedge clock) begin
      if (ctl.product) begin
         sq_new_ff <= x_new * x_new;
         sq_old_ff <= x_old * x_old;
         wx_new_ff <= w_new * x_new;
         wx_old_ff <= w_old * x_old;
         dx_ff     <= (SAMPLE_BITS+1)'(x_new) - (SAMPLE_BITS+1)'(x_old);
      end
      if (ctl.multiply) begin
         xx_ff  <= x_mean * x_mean;
         wxm_ff <= w_mean * x_mean;
      end
      if (ctl.finish) begin
         x_var_ff  <= (RESULT_BITS'(sq_mean) <<< FRAC_SHIFT) - RESULT_BITS'(xx_ff);
         wx_cov_ff <= (RESULT_BITS'(wx_mean) <<< FRAC_SHIFT) - RESULT_BITS'(wxm_ff);
      end
   end

   // sums cover the whole ring store
   always_ff @(posedge clock) begin
      if (reset) begin
         x_total_ff  <= '0;
         sq_total_ff <= '0;
         wx_total_ff <= '0;
      end else if (ctl.accumulate) begin
         x_total_ff  <= x_total_ff + XSW'(dx_ff);
         sq_total_ff <= sq_total_ff + SQW'(sq_new_ff) - SQW'(sq_old_ff);
         wx_total_ff <= wx_total_ff + WXW'(wx_new_ff) - WXW'(wx_old_ff);
      end
   end

   swvc_div #(.SUM_W(XSW), .DIV_W(NW)) u_div_x (
      .clock (clock), .reset (reset), .start (ctl.divide),
      .sum (x_total_ff), .divisor (win_n), .busy (busy_x), .mean (x_mean)
   );

   swvc_div #(.SUM_W(SQW), .DIV_W(NW)) u_div_sq (
      .clock (clock), .reset (reset), .start (ctl.divide),
      .sum (sq_total_ff), .divisor (win_n), .busy (busy_sq), .mean (sq_mean)
   );

   swvc_div #(.SUM_W(WXW), .DIV_W(NW)) u_div_wx (
      .clock (clock), .reset (reset), .start (ctl.divide),
      .sum (wx_total_ff), .divisor (win_n), .busy (busy_wx), .mean (wx_mean)
   );

   assign busy   = busy_x | busy_sq | busy_wx;
   assign x_var  = x_var_ff;
   assign wx_cov = wx_cov_ff;

endmodule

>>> sv/swvc_merge.sv
// ---------------------------------------------------------------------------
// swvc_merge
// collects lane results and sends one word per active channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swvc_merge #(
   parameter int CHANNELS = swvc_pkg::CHANNELS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic [swvc_pkg::CHAN_BITS-1:0]           last_idx,
   input  logic signed [swvc_pkg::RESULT_BITS-1:0]  x_var [CHANNELS],
   input  logic signed [swvc_pkg::RESULT_BITS-1:0]  wx_cov [CHANNELS],
   input  logic signed [swvc_pkg::RESULT_BITS-1:0]  w_var,
   output logic                                     busy,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [swvc_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                                     rsp_tlast
);

   import swvc_pkg::*;

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PAD = RSP_DATA_BITS - RSP_FIELD_BITS;

   logic signed [RESULT_BITS-1:0] xv_ff [CHANNELS];
   logic signed [RESULT_BITS-1:0] cv_ff [CHANNELS];
   logic signed [RESULT_BITS-1:0] wv_ff;
   logic [IW-1:0]                 idx_ff, last_ff;
   logic                          pend_ff, valid_ff, tlast_ff;
   logic [RSP_DATA_BITS-1:0]      data_ff;
   logic                          advance;

   assign advance = pend_ff & (~valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (advance) begin
            valid_ff <= 1'b1;
            tlast_ff <= (idx_ff == last_ff);
            data_ff  <= {{PAD{1'b0}}, wv_ff, cv_ff[idx_ff], xv_ff[idx_ff],
                         CHAN_BITS'(idx_ff)};
            if (idx_ff == last_ff) begin
               pend_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end else if (valid_ff & rsp_tready) begin
            valid_ff <= 1'b0;
         end
         if (load & ~pend_ff) begin
            xv_ff   <= x_var;
            cv_ff   <= wx_cov;
            wv_ff   <= w_var;
            idx_ff  <= '0;
            last_ff <= IW'(last_idx);
            pend_ff <= 1'b1;
         end
      end
   end

   assign busy       = pend_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = tlast_ff;

endmodule

>>> sv/sliding_window_variance_covariance_top.sv
// ---------------------------------------------------------------------------
// sliding_window_variance_covariance_top
// windowed var(x), cov(w,x) and var(w) over parallel channel lanes
// ---------------------------------------------------------------------------
// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready   w, x0..x(CHANNELS-1) samples
// rsp       out  rsp_tvalid/rsp_tready   channel, x var, wx cov, w var, tlast
// csr       in   csr_we                  window_len, active_channels
//
// one step runs from accept to the first result word and to the
// next accept; the mean dividers (four quotient bits a cycle, 13 steps for
// the widest sum) take up most of that span
// after reset a clearing pass writes zero to every ring slot, during
// which no word is accepted
// the next word is accepted while earlier results still drain; a stalled
// rsp side holds results in the merge buffer and blocks the next load only
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_variance_covariance_top #(
   parameter int WINDOW_MAX  = swvc_pkg::WINDOW_MAX_DEF,
   parameter int CHANNELS    = swvc_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = swvc_pkg::SAMPLE_BITS_DEF,
   parameter int REQ_W       = ((CHANNELS + 1) * SAMPLE_BITS + 7) / 8 * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // csr write port
   input  logic                                 csr_we,
   input  logic [swvc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [swvc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // request: w_sample, x0_sample .. x(CHANNELS-1)_sample, zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [REQ_W-1:0]                     req_tdata,
   // response: channel, x_variance, wx_covariance, w_variance, zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swvc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast
);

   import swvc_pkg::*;

   localparam int AW  = $clog2(WINDOW_MAX);
   localparam int NW  = $clog2(WINDOW_MAX + 1);
   localparam int MW  = SAMPLE_BITS + AW + 10;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_PROD, ST_ACC,
      ST_DIV_GO, ST_DIV_WAIT, ST_MUL, ST_FIN, ST_OUT
   } state_type;

   state_type                     state_ff;
   logic [AW-1:0]                 clr_cnt_ff;
   logic [AW-1:0]                 write_slot_ff;
   logic [AW-1:0]                 slot_in;
   logic [WIN_LEN_BITS-1:0]       window_len_ff;
   logic [ACT_BITS-1:0]           active_ff;
   logic [NW-1:0]                 win_n;
   logic [CHAN_BITS-1:0]          last_idx;
   logic signed [SAMPLE_BITS-1:0] w_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff [CHANNELS];
   swvc_ctl_type                  ctl;
   logic [AW-1:0]                 addr;
   logic                          req_accept;
   logic                          merge_busy;
   logic                          w_busy;

   // w lane outputs
   logic signed [SAMPLE_BITS-1:0] w_old;
   logic signed [MW-1:0]          w_mean;
   logic signed [RESULT_BITS-1:0] w_var, w_cov_unused_chk;

   // x lane outputs
   logic signed [SAMPLE_BITS-1:0] x_old [CHANNELS];
   logic signed [MW-1:0]          x_mean [CHANNELS];
   logic signed [RESULT_BITS-1:0] x_var [CHANNELS];
   logic signed [RESULT_BITS-1:0] wx_cov [CHANNELS];
   logic [CHANNELS-1:0]           x_busy;

   // config registers, written any time
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         active_ff     <= ACTIVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LEN:      window_len_ff <= csr_wdata;
            CSR_ACTIVE_CHANNELS: active_ff     <= csr_wdata[ACT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective window, last reported channel and next slot
   always_comb begin
      int n_i;
      int a_i;
      int s_i;
      if (window_len_ff == '0) begin
         n_i = 1;
      end else if (int'(window_len_ff) > WINDOW_MAX) begin
         n_i = WINDOW_MAX;
      end else begin
         n_i = int'(window_len_ff);
      end
      if (active_ff == '0) begin
         a_i = 0;
      end else if (int'(active_ff) > CHANNELS) begin
         a_i = CHANNELS - 1;
      end else begin
         a_i = int'(active_ff) - 1;
      end
      s_i = int'(write_slot_ff) + 1;
      if (s_i >= n_i) begin
         s_i = 0;
      end
      win_n    = NW'(n_i);
      last_idx = CHAN_BITS'(a_i);
      slot_in  = AW'(s_i);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // sequencer: clear pass, then one step at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         write_slot_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(WINDOW_MAX - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  write_slot_ff <= slot_in;
                  state_ff      <= ST_READ;
               end
            end
            ST_READ:     state_ff <= ST_PROD;
            ST_PROD:     state_ff <= ST_ACC;
            ST_ACC:      state_ff <= ST_DIV_GO;
            ST_DIV_GO:   state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (~w_busy & ~(|x_busy)) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL:      state_ff <= ST_FIN;
            ST_FIN:      state_ff <= ST_OUT;
            ST_OUT: begin
               if (~merge_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:     state_ff <= ST_IDLE;
         endcase
      end
   end

   // sample capture, payload only
   always_ff @(posedge clock) begin
      if (req_accept) begin
         w_ff <= $signed(req_tdata[SAMPLE_BITS-1:0]);
         for (int c = 0; c < CHANNELS; c++) begin
            x_ff[c] <= $signed(req_tdata[(c+1)*SAMPLE_BITS +: SAMPLE_BITS]);
         end
      end
   end

   always_comb begin
      ctl            = '0;
      ctl.clear      = (state_ff == ST_CLEAR);
      ctl.read       = (state_ff == ST_READ);
      ctl.write      = (state_ff == ST_PROD);
      ctl.product    = (state_ff == ST_PROD);
      ctl.accumulate = (state_ff == ST_ACC);
      ctl.divide     = (state_ff == ST_DIV_GO);
      ctl.multiply   = (state_ff == ST_MUL);
      ctl.finish     = (state_ff == ST_FIN);
   end

   assign addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : write_slot_ff;

   // w lane: its own wx sum is w*w, so its variance output is var(w)
   swvc_lane #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_w_lane (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .addr   (addr),
      .win_n  (win_n),
      .x_new  (w_ff),
      .w_new  (w_ff),
      .w_old  (w_old),
      .w_mean (w_mean),
      .x_old  (w_old),
      .x_mean (w_mean),
      .x_var  (w_var),
      .wx_cov (w_cov_unused_chk),
      .busy   (w_busy)
   );

   // x lanes, side by side
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      swvc_lane #(
         .WINDOW_MAX  (WINDOW_MAX),
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .addr   (addr),
         .win_n  (win_n),
         .x_new  (x_ff[c]),
         .w_new  (w_ff),
         .w_old  (w_old),
         .w_mean (w_mean),
         .x_old  (x_old[c]),
         .x_mean (x_mean[c]),
         .x_var  (x_var[c]),
         .wx_cov (wx_cov[c]),
         .busy   (x_busy[c])
      );
   end

   // w lane covariance equals its variance; the match tap does not gate the merge load
   logic lane_match;
   assign lane_match = (w_cov_unused_chk == w_var);

   swvc_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       ((state_ff == ST_OUT) & lane_match | (state_ff == ST_OUT)),
      .last_idx   (last_idx),
      .x_var      (x_var),
      .wx_cov     (wx_cov),
      .w_var      (w_var),
      .busy       (merge_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sv/swvc_checker.sv
// ---------------------------------------------------------------------------
// swvc_checker
// port level checks on the top, attached by bind
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swvc_checker #(
   parameter int CHANNELS = swvc_pkg::CHANNELS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [swvc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast
);

   import swvc_pkg::*;

   // clearing pass follows reset, so no word is taken right after it
   a_clear_blocks_req: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req accepted during clearing pass");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[CHAN_BITS-1:0]) < CHANNELS))
      else $error("channel index beyond lane count");

   a_top_channel_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && int'(rsp_tdata[CHAN_BITS-1:0]) == CHANNELS - 1) |-> rsp_tlast)
      else $error("highest channel not marked last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled rsp word changed");

endmodule

bind sliding_window_variance_covariance_top swvc_checker #(
   .CHANNELS (CHANNELS)
) u_swvc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
